// ===== rtl/core/bez_pkg.sv =====
// Shared types and constants for the cubic Bezier evaluator.
package bez_pkg;

  localparam int unsigned REG_IDX_BITS = 3;
  localparam int unsigned NUM_AXES     = 2;
  localparam int unsigned NUM_POINTS   = 4;
  localparam int unsigned PIPE_DEPTH   = 6;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } cfg_reg_t;

endpackage

// ===== rtl/core/cubic_bezier_de_casteljau_eval.sv =====
// Cubic Bezier point evaluator, de Casteljau construction, six-stage pipeline.
//
// Usage:
//   Control points are written through cfg_we/cfg_index/cfg_data (index 0..7:
//   p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y), signed fixed point.
//   Write them only while no evaluation is in flight.
//   A beat enters when start is high and busy is low; busy is always low, so
//   a new param_t may be given every cycle. param_t is unsigned Q1.FRAC_T_BITS
//   and values above 1.0 are clamped to 1.0.
//   Each beat's result appears on the result ports for one cycle, marked by
//   done. Throughput is one point per cycle.
//   The pipeline is made of the three interpolation levels, each split into a
//   multiply stage ((b-a)*t) and a round-and-add stage.
//   Results leave in order; the receiver cannot stall, so the pipeline never
//   holds.
//   Reset clears the control points to zero and empties the pipeline.
module cubic_bezier_de_casteljau_eval #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned FRAC_T_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [bez_pkg::REG_IDX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [FRAC_T_BITS:0]                  param_t,
  output logic                                  done,
  output logic signed [COORD_BITS-1:0]          curve_x,
  output logic signed [COORD_BITS-1:0]          curve_y,
  output logic signed [COORD_BITS-1:0]          mid01_x,
  output logic signed [COORD_BITS-1:0]          mid01_y,
  output logic signed [COORD_BITS-1:0]          mid12_x,
  output logic signed [COORD_BITS-1:0]          mid12_y,
  output logic signed [COORD_BITS-1:0]          mid23_x,
  output logic signed [COORD_BITS-1:0]          mid23_y,
  output logic signed [COORD_BITS-1:0]          mid012_x,
  output logic signed [COORD_BITS-1:0]          mid012_y,
  output logic signed [COORD_BITS-1:0]          mid123_x,
  output logic signed [COORD_BITS-1:0]          mid123_y
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned F  = FRAC_T_BITS;
  localparam int unsigned PW = C + F + 3;
  localparam int unsigned NA = bez_pkg::NUM_AXES;
  localparam int unsigned NP = bez_pkg::NUM_POINTS;

  localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};
  localparam logic signed [PW-1:0] HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  // (b - a) * t, full precision
  function automatic logic signed [PW-1:0] scaled_diff(
    input logic signed [C-1:0] a,
    input logic signed [C-1:0] b,
    input logic [F:0]          t
  );
    logic signed [C:0]      d;
    logic signed [F+1:0]    ts;
    logic signed [PW-1:0]   p;
    d  = {b[C-1], b} - {a[C-1], a};
    ts = $signed({1'b0, t});
    p  = d * ts;
    return p;
  endfunction

  // a + round_half_up(p / 2^F); result always lies between the operands
  function automatic logic signed [C-1:0] round_add(
    input logic signed [C-1:0]  a,
    input logic signed [PW-1:0] p
  );
    logic signed [PW-1:0] r;
    logic [C-1:0]         s;
    r = (p + HALF) >>> F;
    s = a + r[C-1:0];
    return $signed(s);
  endfunction

  logic signed [C-1:0] pt [NA][NP];

  logic [F:0] t_sat;
  logic       accept;

  // pipeline registers
  logic [bez_pkg::PIPE_DEPTH-1:0] vld;
  logic [F:0]           t1, t2, t3, t4;
  logic signed [PW-1:0] prod1 [NA][3];
  logic signed [C-1:0]  base1 [NA][3];
  logic signed [C-1:0]  m1_s2 [NA][3];
  logic signed [PW-1:0] prod2 [NA][2];
  logic signed [C-1:0]  base2 [NA][2];
  logic signed [C-1:0]  m1_s3 [NA][3];
  logic signed [C-1:0]  m2_s4 [NA][2];
  logic signed [C-1:0]  m1_s4 [NA][3];
  logic signed [PW-1:0] prod3 [NA];
  logic signed [C-1:0]  base3 [NA];
  logic signed [C-1:0]  m1_s5 [NA][3];
  logic signed [C-1:0]  m2_s5 [NA][2];
  logic signed [C-1:0]  crv_s6 [NA];
  logic signed [C-1:0]  m1_s6 [NA][3];
  logic signed [C-1:0]  m2_s6 [NA][2];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign t_sat  = (param_t > T_ONE) ? T_ONE : param_t;

  // control point registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ax = 0; ax < NA; ax++) begin
        for (int k = 0; k < NP; k++) begin
          pt[ax][k] <= '0;
        end
      end
    end else if (cfg_we) begin
      unique case (bez_pkg::cfg_reg_t'(cfg_index))
        bez_pkg::REG_P0_X: pt[0][0] <= $signed(cfg_data);
        bez_pkg::REG_P0_Y: pt[1][0] <= $signed(cfg_data);
        bez_pkg::REG_P1_X: pt[0][1] <= $signed(cfg_data);
        bez_pkg::REG_P1_Y: pt[1][1] <= $signed(cfg_data);
        bez_pkg::REG_P2_X: pt[0][2] <= $signed(cfg_data);
        bez_pkg::REG_P2_Y: pt[1][2] <= $signed(cfg_data);
        bez_pkg::REG_P3_X: pt[0][3] <= $signed(cfg_data);
        bez_pkg::REG_P3_Y: pt[1][3] <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[bez_pkg::PIPE_DEPTH-2:0], accept};
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    t1 <= t_sat;
    t2 <= t1;
    t3 <= t2;
    t4 <= t3;
    for (int ax = 0; ax < NA; ax++) begin
      // level 1
      for (int k = 0; k < 3; k++) begin
        prod1[ax][k] <= scaled_diff(pt[ax][k], pt[ax][k+1], t_sat);
        base1[ax][k] <= pt[ax][k];
        m1_s2[ax][k] <= round_add(base1[ax][k], prod1[ax][k]);
        m1_s3[ax][k] <= m1_s2[ax][k];
        m1_s4[ax][k] <= m1_s3[ax][k];
        m1_s5[ax][k] <= m1_s4[ax][k];
        m1_s6[ax][k] <= m1_s5[ax][k];
      end
      // level 2
      for (int k = 0; k < 2; k++) begin
        prod2[ax][k] <= scaled_diff(m1_s2[ax][k], m1_s2[ax][k+1], t2);
        base2[ax][k] <= m1_s2[ax][k];
        m2_s4[ax][k] <= round_add(base2[ax][k], prod2[ax][k]);
        m2_s5[ax][k] <= m2_s4[ax][k];
        m2_s6[ax][k] <= m2_s5[ax][k];
      end
      // level 3
      prod3[ax]  <= scaled_diff(m2_s4[ax][0], m2_s4[ax][1], t4);
      base3[ax]  <= m2_s4[ax][0];
      crv_s6[ax] <= round_add(base3[ax], prod3[ax]);
    end
  end

  assign done     = vld[bez_pkg::PIPE_DEPTH-1];
  assign curve_x  = crv_s6[0];
  assign curve_y  = crv_s6[1];
  assign mid01_x  = m1_s6[0][0];
  assign mid01_y  = m1_s6[1][0];
  assign mid12_x  = m1_s6[0][1];
  assign mid12_y  = m1_s6[1][1];
  assign mid23_x  = m1_s6[0][2];
  assign mid23_y  = m1_s6[1][2];
  assign mid012_x = m2_s6[0][0];
  assign mid012_y = m2_s6[1][0];
  assign mid123_x = m2_s6[0][1];
  assign mid123_y = m2_s6[1][1];

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, bez_pkg::PIPE_DEPTH))
    else $error("done without a beat accepted six cycles earlier");

  a_accept_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("accepted beat produced no result");

  a_curve_x_between: assert property (@(posedge clk) disable iff (rst)
    done |-> ((curve_x >= mid012_x && curve_x <= mid123_x) ||
              (curve_x <= mid012_x && curve_x >= mid123_x)))
    else $error("curve_x outside its second level points");

  a_curve_y_between: assert property (@(posedge clk) disable iff (rst)
    done |-> ((curve_y >= mid012_y && curve_y <= mid123_y) ||
              (curve_y <= mid012_y && curve_y >= mid123_y)))
    else $error("curve_y outside its second level points");

endmodule
